>>> src/bfa_pkg.sv
package bfa_pkg;

  localparam int unsigned NumFramesDef  = 32768;
  localparam int unsigned FrameBytesDef = 4096;

  localparam int unsigned WordBits = 32;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned PhysW    = 32;
  localparam int unsigned AddrOutW = 27;
  localparam int unsigned CountOutW = 16;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               found;
    logic [BitIdxW-1:0] bit_idx;
  } find_res_t;

endpackage

>>> src/bfa_ram.sv
module bfa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bfa_find_zero.sv
module bfa_find_zero (
  input  logic [bfa_pkg::WordBits-1:0] word_i,
  output bfa_pkg::find_res_t           res_o
);
  import bfa_pkg::*;

  always_comb begin
    res_o = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        res_o.found   = 1'b1;
        res_o.bit_idx = BitIdxW'(i);
      end
    end
  end

endmodule

>>> src/bitmap_frame_allocator.sv
// Channel   Dir  Beat fields (lowest bit up)
// s_axis    in   command[1:0], byte_addr[33:2], zero fill to 40 bits
// m_axis    out  frame_addr[26:0], success[27], free_count[43:28], zero fill to 48 bits
//
// An in-range free or reserve passes from accept through ST_EVAL and ST_DONE into the output
// register; an allocate with free frames stays in ST_EVAL for each 32-bit bitmap word scanned,
// starting at the lowest word that may hold a free frame. Any other beat goes from accept to ST_DONE.
// After reset the bitmap RAM is cleared one word per cycle, and no beat is accepted meanwhile.
// A finished result waits in the output register while m_axis_tready is low.
module bitmap_frame_allocator #(
  parameter int unsigned NumFrames  = bfa_pkg::NumFramesDef,
  parameter int unsigned FrameBytes = bfa_pkg::FrameBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // command[1:0], byte_addr[33:2]
  input  logic [bfa_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_addr[26:0], success[27], free_count[43:28]
  output logic [bfa_pkg::OutTdataW-1:0]  m_axis_tdata
);
  import bfa_pkg::*;

  localparam int unsigned Words     = (NumFrames + WordBits - 1) / WordBits;
  localparam int unsigned AW        = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CW        = $clog2(NumFrames + 1);
  localparam int unsigned FbShift   = $clog2(FrameBytes);
  localparam int unsigned LastValid = NumFrames - (Words - 1) * WordBits;
  localparam logic [WordBits-1:0] PadMask =
    (LastValid >= WordBits) ? '0 : ({WordBits{1'b1}} << LastValid);
  localparam logic [AW-1:0] LastWord = AW'(Words - 1);

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [AW-1:0]        word_q, word_d;
  logic [BitIdxW-1:0]   bit_q, bit_d;
  logic [AW-1:0]        hint_q, hint_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AddrOutW-1:0]  res_addr_q, res_addr_d;
  logic                 res_ok_q, res_ok_d;
  logic                 out_valid_q, out_valid_d;
  logic [AddrOutW-1:0]  out_addr_q, out_addr_d;
  logic                 out_ok_q, out_ok_d;
  logic [CountOutW-1:0] out_cnt_q, out_cnt_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WordBits-1:0]  ram_wdata, ram_rdata;

  logic [WordBits-1:0]  scan_word;
  find_res_t            find;
  logic                 accept;
  logic [CmdW-1:0]      in_cmd;
  logic [PhysW-1:0]     in_frame;
  logic                 in_range;
  logic [63:0]          alloc_wide;
  logic [63:0]          cnt_wide;
  logic [WordBits-1:0]  bit_mask;

  bfa_ram #(
    .Width (WordBits),
    .Depth (Words)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign scan_word = ram_rdata | ((word_q == LastWord) ? PadMask : '0);

  bfa_find_zero u_find (
    .word_i (scan_word),
    .res_o  (find)
  );

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd     = s_axis_tdata[CmdW-1:0];
  assign in_frame   = s_axis_tdata[CmdW +: PhysW] >> FbShift;
  assign in_range   = in_frame < PhysW'(NumFrames);
  assign alloc_wide = 64'({word_q, find.bit_idx}) << FbShift;
  assign cnt_wide   = 64'(count_q);
  assign bit_mask   = WordBits'(1) << bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      word_q      <= '0;
      hint_q      <= '0;
      count_q     <= CW'(NumFrames);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      hint_q      <= hint_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    bit_q      <= bit_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    out_addr_q <= out_addr_d;
    out_ok_q   <= out_ok_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    word_d        = word_q;
    bit_d         = bit_q;
    hint_d        = hint_q;
    count_d       = count_q;
    res_addr_d    = res_addr_q;
    res_ok_d      = res_ok_q;
    out_addr_d    = out_addr_q;
    out_ok_d      = out_ok_q;
    out_cnt_d     = out_cnt_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = word_q;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = word_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (word_q == LastWord) begin
          word_d  = '0;
          state_d = ST_IDLE;
        end else begin
          word_d = word_q + AW'(1);
        end
      end

      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          priority case (in_cmd)
            CMD_ALLOC: begin
              cmd_d = CMD_ALLOC;
              if (count_q == '0) begin
                state_d = ST_DONE;
              end else begin
                word_d    = hint_q;
                ram_re    = 1'b1;
                ram_raddr = hint_q;
                state_d   = ST_EVAL;
              end
            end
            CMD_FREE, CMD_RESERVE: begin
              cmd_d = cmd_e'(in_cmd);
              if (in_range) begin
                word_d    = in_frame[BitIdxW +: AW];
                bit_d     = in_frame[BitIdxW-1:0];
                ram_re    = 1'b1;
                ram_raddr = in_frame[BitIdxW +: AW];
                state_d   = ST_EVAL;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_EVAL: begin
        unique case (cmd_q)
          CMD_ALLOC: begin
            if (find.found) begin
              ram_we     = 1'b1;
              ram_wdata  = ram_rdata | (WordBits'(1) << find.bit_idx);
              hint_d     = word_q;
              count_d    = count_q - CW'(1);
              res_ok_d   = 1'b1;
              res_addr_d = alloc_wide[AddrOutW-1:0];
              state_d    = ST_DONE;
            end else begin
              word_d    = word_q + AW'(1);
              ram_re    = 1'b1;
              ram_raddr = word_q + AW'(1);
            end
          end
          CMD_FREE: begin
            if (ram_rdata[bit_q]) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~bit_mask;
              count_d   = count_q + CW'(1);
              hint_d    = (word_q < hint_q) ? word_q : hint_q;
              res_ok_d  = 1'b1;
            end
            state_d = ST_DONE;
          end
          CMD_RESERVE: begin
            if (!ram_rdata[bit_q]) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | bit_mask;
              count_d   = count_q - CW'(1);
              res_ok_d  = 1'b1;
            end
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_ok_d    = res_ok_q;
          out_cnt_d   = cnt_wide[CountOutW-1:0];
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - AddrOutW - 1 - CountOutW){1'b0}},
                          out_cnt_q, out_ok_q, out_addr_q};

  a_alloc_finds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && cmd_q == CMD_ALLOC && word_q == LastWord) |-> find.found)
    else $error("allocation scan reached the last word without a free frame");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NumFrames))
    else $error("free count exceeds the number of frames");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input ready during bitmap clearing");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input ready again right after an accepted beat");

endmodule

>>> tb/sv/bfa_alloc_checker.sv
`timescale 1ns / 100ps
module bfa_alloc_checker #(
  parameter int unsigned NumFrames  = bfa_pkg::NumFramesDef,
  parameter int unsigned FrameBytes = bfa_pkg::FrameBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // command[1:0], byte_addr[33:2]
  input  logic [bfa_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_addr[26:0], success[27], free_count[43:28]
  input  logic [bfa_pkg::OutTdataW-1:0]  m_axis_tdata,
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    alloc_fail_o
);
  import bfa_pkg::*;

  typedef struct packed {
    logic [AddrOutW-1:0]  frame_addr;
    logic                 success;
    logic [CountOutW-1:0] free_count;
  } frame_result_t;

  frame_result_t expected_q[$];
  bit            frame_used[NumFrames];
  int unsigned   free_total;
  int unsigned   scan_start;

  // The scan start only skips frames known to be used, so first fit is kept.
  function automatic frame_result_t apply_command(input logic [CmdW-1:0] cmd,
                                                  input logic [PhysW-1:0] addr);
    frame_result_t res;
    int unsigned   frame;
    int unsigned   f;
    res   = '0;
    frame = addr / FrameBytes;
    case (cmd)
      CMD_ALLOC: begin
        for (f = scan_start; f < NumFrames && frame_used[f]; f++);
        if (f < NumFrames) begin
          frame_used[f]  = 1'b1;
          free_total--;
          res.frame_addr = AddrOutW'(f * FrameBytes);
          res.success    = 1'b1;
          scan_start     = f + 1;
        end else begin
          scan_start = NumFrames;
          alloc_fail_o++;
        end
      end
      CMD_FREE: begin
        if (frame < NumFrames && frame_used[frame]) begin
          frame_used[frame] = 1'b0;
          free_total++;
          res.success = 1'b1;
          if (frame < scan_start) scan_start = frame;
        end
      end
      CMD_RESERVE: begin
        if (frame < NumFrames && !frame_used[frame]) begin
          frame_used[frame] = 1'b1;
          free_total--;
          res.success = 1'b1;
        end
      end
      default: ;
    endcase
    res.free_count = CountOutW'(free_total);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst_ni) begin
      foreach (frame_used[i]) frame_used[i] = 1'b0;
      free_total    = NumFrames;
      scan_start    = 0;
      expected_q.delete();
      error_count_o = 0;
      pending_o     = 0;
      checked_o     = 0;
      alloc_fail_o  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.frame_addr = m_axis_tdata[26:0];
        got.success    = m_axis_tdata[27];
        got.free_count = m_axis_tdata[43:28];
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: addr %h success %b count %0d",
                   $time, got.frame_addr, got.success, got.free_count);
          error_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (got.frame_addr !== want.frame_addr) begin
            $display("%0t: frame_addr expected %h actual %h", $time, want.frame_addr,
                     got.frame_addr);
            error_count_o++;
          end
          if (got.success !== want.success) begin
            $display("%0t: success expected %b actual %b", $time, want.success, got.success);
            error_count_o++;
          end
          if (got.free_count !== want.free_count) begin
            $display("%0t: free_count expected %0d actual %0d", $time, want.free_count,
                     got.free_count);
            error_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_command(s_axis_tdata[1:0], s_axis_tdata[33:2]));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> tb/sv/tb_bitmap_frame_allocator.sv
`timescale 1ns / 100ps
module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam int unsigned NumFrames  = NumFramesDef;
  localparam int unsigned FrameBytes = FrameBytesDef;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [PhysW-1:0] TopAddr = PhysW'(NumFrames * FrameBytes - 1);
  localparam logic [PhysW-1:0] EndAddr = PhysW'(NumFrames * FrameBytes);
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned TailCycles = 64;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InTdataW-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutTdataW-1:0]  m_axis_tdata;

  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned alloc_fails;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned rx_cycle;
  int unsigned rx_mode;

  bitmap_frame_allocator #(
    .NumFrames (NumFrames),
    .FrameBytes(FrameBytes)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bfa_alloc_checker #(
    .NumFrames (NumFrames),
    .FrameBytes(FrameBytes)
  ) alloc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .error_count_o(error_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .alloc_fail_o (alloc_fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_beat(input logic [CmdW-1:0] cmd, input logic [PhysW-1:0] addr);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(24, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({addr, cmd});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned       pick;
    int unsigned       frame;
    logic [PhysW-1:0]  addr;
    pick  = $urandom_range(99);
    frame = ($urandom_range(7) == 0) ? $urandom_range(NumFrames - 1) : $urandom_range(127);
    addr  = PhysW'(frame * FrameBytes + $urandom_range(FrameBytes - 1));
    if (pick < 35) begin
      send_beat(CMD_ALLOC, $urandom());
    end else if (pick < 65) begin
      send_beat(CMD_FREE, addr);
    end else if (pick < 85) begin
      send_beat(CMD_RESERVE, addr);
    end else if (pick < 95) begin
      send_beat(($urandom_range(1) == 0) ? CMD_FREE : CMD_RESERVE, $urandom());
    end else begin
      send_beat(CmdUnused, $urandom());
    end
  endtask

  // The receiver changes its stall behavior periodically, picking one of four modes at random.
  always @(posedge clk_i) begin
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(3);
    rx_cycle++;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(1);
      2:       m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= ((rx_cycle % 32) >= 20);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
               idle_cycles, pending);
      $display("bitmap_frame_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(CMD_ALLOC, '0);
    send_beat(CMD_ALLOC, $urandom());
    send_beat(CMD_FREE, 32'h0000_0000);
    send_beat(CMD_FREE, 32'h0000_0FFF);
    send_beat(CMD_ALLOC, $urandom());
    send_beat(CMD_RESERVE, 32'h0000_5FFF);
    send_beat(CMD_RESERVE, 32'h0000_5000);
    send_beat(CMD_FREE, 32'h0000_5ABC);
    send_beat(CMD_RESERVE, TopAddr);
    send_beat(CMD_FREE, EndAddr);
    send_beat(CMD_RESERVE, EndAddr);
    send_beat(CMD_FREE, 32'hFFFF_FFFF);
    send_beat(CMD_RESERVE, 32'hFFFF_FFFF);
    send_beat(CmdUnused, 32'hFFFF_FFFF);
    send_beat(CmdUnused, 32'h0000_0000);
    send_beat(CMD_FREE, TopAddr & ~PhysW'(FrameBytes - 1));
    send_beat(CMD_ALLOC, 32'hFFFF_FFFF);
    send_beat(CMD_FREE, 32'h0000_1000);
    send_beat(CMD_ALLOC, $urandom());
    send_beat(CMD_RESERVE, 32'h0000_0000);

    repeat (250) send_random_item();

    send_beat(CMD_FREE, TopAddr);
    send_beat(CMD_ALLOC, $urandom());
    send_beat(CMD_ALLOC, $urandom());
    send_beat(CMD_RESERVE, 32'h0400_0000);
    send_beat(CMD_FREE, 32'h0400_0123);
    send_beat(CMD_ALLOC, $urandom());

    repeat (270) send_random_item();

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d result beats over allocate, free, reserve and unused commands,",
             checked);
    $display("with out-of-range addresses and %0d allocations that found no free frame.",
             alloc_fails);
    if (error_count == 0) begin
      $display("bitmap_frame_allocator regression: pass");
    end else begin
      $display("bitmap_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule
